// File: rtl/cbm_pkg.sv
`default_nettype none

package cbm_pkg;

    // Default sizes
    localparam int RAM_BYTES_DEF    = 32768;
    localparam int MAX_ROM_BANK_DEF = 31;

    // Fixed field widths
    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int OFFSET_W  = 19;
    localparam int BANK_W    = 8;
    localparam int RAM_WIN_W = 13;
    localparam int ROM_WIN_W = 14;

    // Address regions, decoded from address[15:13]
    localparam logic [2:0] REG_RAM_EN   = 3'b000;
    localparam logic [2:0] REG_ROM_LOW  = 3'b001;
    localparam logic [2:0] REG_ROM_HIGH = 3'b010;
    localparam logic [2:0] REG_MODE     = 3'b011;
    localparam logic [2:0] REG_RAM_WIN  = 3'b101;

    // Access kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Decoded access, handed from the control stage down the pipe
    typedef struct packed {
        logic                mapped;
        logic                is_rom;
        logic [OFFSET_W-1:0] rom_offset;
        logic                ram_enabled;
        logic                ram_rd;
        logic                ram_we;
    } cbm_access_t;

endpackage

`default_nettype wire

// File: rtl/cartridge_bank_mapper.sv
`default_nettype none

// Cartridge bank mapper: one CPU bus access in, one result out.
// Input beat: s_axis_tuser is the access kind (0 read, 1 write), s_axis_tdata
// carries the address and the write byte. Writes to 0x0000-0x7fff set the
// bank registers and flags; reads of 0x0000-0x7fff return a cartridge ROM
// byte address; 0xa000-0xbfff reads and writes the on-chip banked RAM.
// Output beat: m_axis_tuser flags mapped and ROM; m_axis_tdata carries the
// ROM offset, the RAM byte and the current RAM enable flag.
// Beats pass the RAM read stage and the output register, one per cycle while
// m_axis_tready is high. Bank registers update and the RAM is accessed
// at the input beat (one single-port RAM access per beat, registered read),
// so back-to-back accesses to one RAM byte see each other without forwarding.
// A stalled receiver holds the output beat; one more access is taken into
// the RAM read stage, then s_axis_tready drops until the output drains.
// Reset clears the bank registers (ROM bank low to 1, the rest to 0) and the
// pipeline; RAM contents are undefined until written. No clearing pass.
module cartridge_bank_mapper
    import cbm_pkg::*;
#(
    parameter int RAM_BYTES    = RAM_BYTES_DEF,
    parameter int MAX_ROM_BANK = MAX_ROM_BANK_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [15:0] address, [23:16] write_data
    input  wire logic        s_axis_tuser,   // [0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // [18:0] rom_offset, [26:19] ram_read_data,
                                             // [27] ram_enabled, [31:28] zero
    output logic      [1:0]  m_axis_tuser    // [0] mapped, [1] is_rom
);

    localparam int RAM_AW = $clog2(RAM_BYTES);

    logic              accept;
    logic              s1_adv;
    cbm_access_t       access;
    logic [RAM_AW-1:0] ram_addr;
    logic [DATA_W-1:0] ram_q;
    logic [DATA_W-1:0] s1_rdata;

    logic              s1_valid_reg;
    cbm_access_t       s1_info_reg;
    logic              out_valid_reg;
    cbm_access_t       out_info_reg;
    logic [DATA_W-1:0] out_rdata_reg;

    // Handshake: stage 1 moves on when the output slot is free or drains
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cbm_ctrl #(
        .RAM_BYTES    (RAM_BYTES),
        .MAX_ROM_BANK (MAX_ROM_BANK),
        .RAM_AW       (RAM_AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .kind       (s_axis_tuser),
        .address    (s_axis_tdata[15:0]),
        .write_data (s_axis_tdata[23:16]),
        .access     (access),
        .ram_addr   (ram_addr)
    );

    cbm_ram #(
        .DEPTH (RAM_BYTES),
        .AW    (RAM_AW)
    ) u_ram (
        .clk   (clk),
        .en    (accept && (access.ram_rd || access.ram_we)),
        .we    (access.ram_we),
        .addr  (ram_addr),
        .wdata (s_axis_tdata[23:16]),
        .rdata (ram_q)
    );

    assign s1_rdata = s1_info_reg.ram_rd ? ram_q : '0;

    // Advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold or advance the payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg <= access;
        end
        if (s1_adv)
        begin
            out_info_reg  <= s1_info_reg;
            out_rdata_reg <= s1_rdata;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = {out_info_reg.is_rom, out_info_reg.mapped};
    assign m_axis_tdata  = {4'b0, out_info_reg.ram_enabled, out_rdata_reg,
                            out_info_reg.rom_offset};

    // A ROM result is always a mapped one
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
        else $error("ROM result not marked mapped");

    // Offsets outside ROM reads stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[1]) |-> (m_axis_tdata[18:0] == 19'd0))
        else $error("non-ROM result carries an offset");

    // The switchable bank never exceeds the clamp (only checkable below 32 banks)
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |->
            ((MAX_ROM_BANK > 31) || (m_axis_tdata[18:14] <= 5'(MAX_ROM_BANK))))
        else $error("ROM bank above clamp");

    // Input stalls only behind a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && s1_valid_reg))
        else $error("input stalled with room in the pipe");

endmodule

`default_nettype wire

// File: rtl/cbm_ram.sv
`default_nettype none

module cbm_ram
    import cbm_pkg::*;
#(
    parameter int DEPTH = RAM_BYTES_DEF,
    parameter int AW    = $clog2(RAM_BYTES_DEF)
)
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic              we,
    input  wire logic [AW-1:0]     addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Single port: write or registered read, one per cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/cbm_ctrl.sv
`default_nettype none

module cbm_ctrl
    import cbm_pkg::*;
#(
    parameter int RAM_BYTES    = RAM_BYTES_DEF,
    parameter int MAX_ROM_BANK = MAX_ROM_BANK_DEF,
    parameter int RAM_AW       = $clog2(RAM_BYTES_DEF)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              kind,
    input  wire logic [ADDR_W-1:0] address,
    input  wire logic [DATA_W-1:0] write_data,
    output cbm_access_t            access,
    output logic      [RAM_AW-1:0] ram_addr
);

    localparam logic [16:0]       RAM_ONE  = 17'(RAM_BYTES);
    localparam logic [16:0]       RAM_TWO  = 17'(2 * RAM_BYTES);
    localparam logic [BANK_W-1:0] BANK_MAX = BANK_W'(MAX_ROM_BANK);
    localparam logic [DATA_W-1:0] LOW_ZERO = 8'h00;
    localparam logic [DATA_W-1:0] LOW_HOLE_A = 8'h20;
    localparam logic [DATA_W-1:0] LOW_HOLE_B = 8'h40;
    localparam logic [DATA_W-1:0] LOW_HOLE_C = 8'h60;

    logic [6:0] rom_bank_low_reg,  rom_bank_low_next;
    logic [1:0] rom_bank_high_reg, rom_bank_high_next;
    logic [1:0] ram_sel_reg,       ram_sel_next;
    logic       ram_mode_reg,      ram_mode_next;
    logic       ram_en_reg,        ram_en_next;

    logic [2:0]        region;
    logic              is_write;
    logic [BANK_W-1:0] bank_sum;
    logic [BANK_W-1:0] bank_clamped;
    logic [16:0]       idx_raw;
    logic [16:0]       idx_half;
    logic [16:0]       idx_mod;

    assign region   = address[15:13];
    assign is_write = (kind == KIND_WRITE);

    // Combine and clamp the switchable ROM bank
    assign bank_sum     = {1'b0, rom_bank_high_reg, 5'b0} + {1'b0, rom_bank_low_reg};
    assign bank_clamped = (bank_sum > BANK_MAX) ? BANK_MAX : bank_sum;

    // Fold the banked RAM index into the RAM size
    assign idx_raw  = {2'b0, ram_sel_reg, address[RAM_WIN_W-1:0]};
    assign idx_half = (idx_raw >= RAM_TWO) ? (idx_raw - RAM_TWO) : idx_raw;
    assign idx_mod  = (idx_half >= RAM_ONE) ? (idx_half - RAM_ONE) : idx_half;
    assign ram_addr = idx_mod[RAM_AW-1:0];

    // Compute register updates for a write beat
    always_comb
    begin
        rom_bank_low_next  = rom_bank_low_reg;
        rom_bank_high_next = rom_bank_high_reg;
        ram_sel_next       = ram_sel_reg;
        ram_mode_next      = ram_mode_reg;
        ram_en_next        = ram_en_reg;
        if (is_write)
        begin
            unique case (region)
                REG_RAM_EN:
                begin
                    ram_en_next = (write_data & 8'h0a) != 8'h00;
                end
                REG_ROM_LOW:
                begin
                    case (write_data) inside
                        LOW_ZERO:
                            rom_bank_low_next = 7'd1;
                        LOW_HOLE_A, LOW_HOLE_B, LOW_HOLE_C:
                            rom_bank_low_next = write_data[6:0] + 7'd1;
                        default:
                            rom_bank_low_next = {2'b0, write_data[4:0]};
                    endcase
                end
                REG_ROM_HIGH:
                begin
                    if (ram_mode_reg)
                    begin
                        ram_sel_next = write_data[1:0];
                    end
                    else if (write_data[7:2] == 6'd0)
                    begin
                        rom_bank_high_next = write_data[1:0];
                    end
                end
                REG_MODE:
                begin
                    ram_mode_next = write_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Build the result of this beat
    always_comb
    begin
        access             = '0;
        access.ram_enabled = ram_en_next;
        if (is_write)
        begin
            unique case (region) inside
                REG_RAM_EN, REG_ROM_LOW, REG_ROM_HIGH, REG_MODE:
                    access.mapped = 1'b1;
                REG_RAM_WIN:
                begin
                    access.mapped = 1'b1;
                    access.ram_we = 1'b1;
                end
                default:
                    access.mapped = 1'b0;
            endcase
        end
        else
        begin
            unique case (region) inside
                REG_RAM_EN, REG_ROM_LOW:
                begin
                    access.mapped     = 1'b1;
                    access.is_rom     = 1'b1;
                    access.rom_offset = {5'b0, address[ROM_WIN_W-1:0]};
                end
                REG_ROM_HIGH, REG_MODE:
                begin
                    access.mapped     = 1'b1;
                    access.is_rom     = 1'b1;
                    access.rom_offset = {bank_clamped[4:0], address[ROM_WIN_W-1:0]};
                end
                REG_RAM_WIN:
                begin
                    access.mapped = 1'b1;
                    access.ram_rd = 1'b1;
                end
                default:
                    access.mapped = 1'b0;
            endcase
        end
    end

    // Commit register updates on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_low_reg  <= 7'd1;
            rom_bank_high_reg <= 2'd0;
            ram_sel_reg       <= 2'd0;
            ram_mode_reg      <= 1'b0;
            ram_en_reg        <= 1'b0;
        end
        else if (accept)
        begin
            rom_bank_low_reg  <= rom_bank_low_next;
            rom_bank_high_reg <= rom_bank_high_next;
            ram_sel_reg       <= ram_sel_next;
            ram_mode_reg      <= ram_mode_next;
            ram_en_reg        <= ram_en_next;
        end
    end

endmodule

`default_nettype wire
